FILE: hw/rtl/trm_pkg.sv
// Shared types and codes for the register machine executor.
// No dependencies; every other file in hw/rtl except trm_if.sv refers to this package.
`default_nettype none

package trm_pkg;

	typedef enum logic [4:0] {
		OP_MOV_RR  = 5'd0,
		OP_MOV_RK  = 5'd1,
		OP_MOV_MR  = 5'd2,
		OP_MOV_RM  = 5'd3,
		OP_MOV_MK  = 5'd4,
		OP_ADD_K   = 5'd5,
		OP_ADD_R   = 5'd6,
		OP_ADD_M   = 5'd7,
		OP_SUB_K   = 5'd8,
		OP_SUB_R   = 5'd9,
		OP_SUB_M   = 5'd10,
		OP_JMPZ    = 5'd11,
		OP_JPN     = 5'd12,
		OP_JMP     = 5'd13,
		OP_PRN_R   = 5'd14,
		OP_PRN_K   = 5'd15,
		OP_PRN_M   = 5'd16,
		OP_HLT     = 5'd17
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MEM  = 2'd1,
		ST_JUMP = 2'd2,
		ST_HALT = 2'd3
	} status_t;

	typedef struct packed {
		logic [4:0]  op;
		logic [2:0]  reg_a;
		logic [2:0]  reg_b;
		logic [7:0]  mem_addr;
		logic [30:0] constant;
		logic [15:0] target_line;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               print_valid;
		logic signed [31:0] print_value;
		logic [16:0]        next_line;
	} result_t;

	// state updates produced by one executed instruction
	typedef struct packed {
		logic        reg_we;
		logic [2:0]  reg_idx;
		logic [31:0] reg_wdata;
		logic        mem_we;
		logic [7:0]  mem_addr;
		logic [31:0] mem_wdata;
	} writeback_t;

endpackage

`default_nettype wire

FILE: hw/rtl/trm_if.sv
// Valid/ready channel interfaces for instruction words and result words.
// Depends on nothing; the payload widths follow the instruction format.
`default_nettype none

interface trm_in_if;
	logic        valid;
	logic        ready;
	logic [4:0]  op;
	logic [2:0]  reg_a;
	logic [2:0]  reg_b;
	logic [7:0]  mem_addr;
	logic [30:0] constant;
	logic [15:0] target_line;

	modport source (output valid, op, reg_a, reg_b, mem_addr, constant, target_line,
		input ready);
	modport sink (input valid, op, reg_a, reg_b, mem_addr, constant, target_line,
		output ready);
endinterface

interface trm_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic               print_valid;
	logic signed [31:0] print_value;
	logic [16:0]        next_line;

	modport source (output valid, status, print_valid, print_value, next_line,
		input ready);
	modport sink (input valid, status, print_valid, print_value, next_line,
		output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/toy_register_machine_executor_core.sv
// Words are registered in stage s1 and execute there; results are registered for
// output. Throughput: one instruction per cycle unless the output stalls; operand
// reads at accept forward from the instruction executing in the same cycle. Reset:
// registers zero, memory entries read as zero until written (valid bits), current
// line 1, program length 1; no clearing pass. Depends on trm_pkg, trm_if.
`default_nettype none

module toy_register_machine_executor_core #(
	parameter int NUM_REGS  = 5,
	parameter int MEM_WORDS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	trm_in_if.sink           in_ch,
	trm_out_if.source        out_ch
);

	localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	logic                s1_valid_q;
	trm_pkg::item_t      item_s1;
	logic [31:0]         ra_val_s1;
	logic [31:0]         rb_val_s1;
	logic [31:0]         rf_q [NUM_REGS];
	logic [16:0]         cur_line_q;
	logic [15:0]         prog_lines_q;
	logic                out_valid_q;
	trm_pkg::result_t    res_q;

	trm_pkg::item_t      in_item;
	trm_pkg::result_t    res;
	trm_pkg::writeback_t wb;
	logic [31:0]         mval;
	logic [31:0]         ra_rd;
	logic [31:0]         rb_rd;
	logic                fire;
	logic                accept;

	assign fire   = s1_valid_q && (!out_valid_q || out_ch.ready);
	assign accept = in_ch.valid && in_ch.ready;

	assign in_ch.ready = !s1_valid_q || fire;

	assign in_item.op          = in_ch.op;
	assign in_item.reg_a       = in_ch.reg_a;
	assign in_item.reg_b       = in_ch.reg_b;
	assign in_item.mem_addr    = in_ch.mem_addr;
	assign in_item.constant    = in_ch.constant;
	assign in_item.target_line = in_ch.target_line;

	// register operand read with bypass of the write landing this cycle
	always_comb begin
		if (fire && wb.reg_we && (wb.reg_idx == in_ch.reg_a)) begin
			ra_rd = wb.reg_wdata;
		end else if ({1'b0, in_ch.reg_a} < 4'(NUM_REGS)) begin
			ra_rd = rf_q[in_ch.reg_a[RW-1:0]];
		end else begin
			ra_rd = 32'd0;
		end
		if (fire && wb.reg_we && (wb.reg_idx == in_ch.reg_b)) begin
			rb_rd = wb.reg_wdata;
		end else if ({1'b0, in_ch.reg_b} < 4'(NUM_REGS)) begin
			rb_rd = rf_q[in_ch.reg_b[RW-1:0]];
		end else begin
			rb_rd = 32'd0;
		end
	end

	trm_dmem #(
		.MEM_WORDS(MEM_WORDS)
	) u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_ch.mem_addr),
		.wr_en   (fire),
		.wb      (wb),
		.rd_data (mval)
	);

	trm_exec #(
		.NUM_REGS (NUM_REGS),
		.MEM_WORDS(MEM_WORDS)
	) u_exec (
		.item      (item_s1),
		.ra_val    (ra_val_s1),
		.rb_val    (rb_val_s1),
		.mval      (mval),
		.cur_line  (cur_line_q),
		.prog_lines(prog_lines_q),
		.res       (res),
		.wb        (wb)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1   <= in_item;
			ra_val_s1 <= ra_rd;
			rb_val_s1 <= rb_rd;
		end
		if (fire) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			cur_line_q   <= 17'd1;
			prog_lines_q <= 16'd1;
			for (int i = 0; i < NUM_REGS; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (fire) begin
				s1_valid_q <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
				cur_line_q  <= res.next_line;
				if (wb.reg_we) begin
					rf_q[wb.reg_idx[RW-1:0]] <= wb.reg_wdata;
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				prog_lines_q <= cfg_wdata;
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = res_q.status;
	assign out_ch.print_valid = res_q.print_valid;
	assign out_ch.print_value = res_q.print_value;
	assign out_ch.next_line   = res_q.next_line;

endmodule

`default_nettype wire

FILE: hw/rtl/trm_dmem.sv
// Data memory with per-entry valid bits, registered read and write forwarding.
// Depends on trm_pkg for the write-back struct.
`default_nettype none

module trm_dmem #(
	parameter int MEM_WORDS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rd_en,
	input  wire logic [7:0]         rd_addr,
	input  wire logic               wr_en,
	input  wire trm_pkg::writeback_t wb,
	output logic [31:0]             rd_data
);

	localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

	logic [31:0]          mem [MEM_WORDS];
	logic [MEM_WORDS-1:0] valid_q;
	logic [31:0]          raw_s1;
	logic                 vld_s1;
	logic                 hit_s1;
	logic [31:0]          fwd_s1;
	logic                 rd_in_range;
	logic [AW-1:0]        rd_idx;
	logic [AW-1:0]        wr_idx;

	assign rd_in_range = {1'b0, rd_addr} < 9'(MEM_WORDS);
	assign rd_idx      = rd_addr[AW-1:0];
	assign wr_idx      = wb.mem_addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en && wb.mem_we) begin
			mem[wr_idx] <= wb.mem_wdata;
		end
		if (rd_en) begin
			raw_s1 <= mem[rd_idx];
			fwd_s1 <= wb.mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
			hit_s1  <= 1'b0;
		end else begin
			if (wr_en && wb.mem_we) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= rd_in_range && valid_q[rd_idx];
				// take the word being written this cycle instead of the stale entry
				hit_s1 <= wr_en && wb.mem_we && (wb.mem_addr == rd_addr);
			end
		end
	end

	assign rd_data = hit_s1 ? fwd_s1 : (vld_s1 ? raw_s1 : 32'd0);

endmodule

`default_nettype wire

FILE: hw/rtl/trm_exec.sv
// Execute logic: decodes one instruction word against its operands and
// produces the result word and the state updates. Depends on trm_pkg.
`default_nettype none

module trm_exec #(
	parameter int NUM_REGS  = 5,
	parameter int MEM_WORDS = 64
) (
	input  wire trm_pkg::item_t    item,
	input  wire logic [31:0]       ra_val,
	input  wire logic [31:0]       rb_val,
	input  wire logic [31:0]       mval,
	input  wire logic [16:0]       cur_line,
	input  wire logic [15:0]       prog_lines,
	output trm_pkg::result_t       res,
	output trm_pkg::writeback_t    wb
);

	logic        addr_ok;
	logic        ra_ok;
	logic        rb_ok;
	logic        uses_mem;
	logic        taken;
	logic [31:0] k32;
	logic [16:0] tgt17;
	logic [16:0] jump_limit;

	assign addr_ok    = {1'b0, item.mem_addr} < 9'(MEM_WORDS);
	assign ra_ok      = {1'b0, item.reg_a} < 4'(NUM_REGS);
	assign rb_ok      = {1'b0, item.reg_b} < 4'(NUM_REGS);
	assign k32        = {1'b0, item.constant};
	assign tgt17      = {1'b0, item.target_line};
	assign jump_limit = {1'b0, prog_lines} + 17'd1;

	assign uses_mem = (item.op == trm_pkg::OP_MOV_MR) || (item.op == trm_pkg::OP_MOV_RM) ||
		(item.op == trm_pkg::OP_MOV_MK) || (item.op == trm_pkg::OP_ADD_M) ||
		(item.op == trm_pkg::OP_SUB_M) || (item.op == trm_pkg::OP_PRN_M);

	always_comb begin
		unique case (item.op)
			trm_pkg::OP_JMP:  taken = 1'b1;
			trm_pkg::OP_JMPZ: taken = ra_ok && (ra_val == 32'd0);
			trm_pkg::OP_JPN:  taken = ra_ok && ((ra_val == 32'd0) || ra_val[31]);
			default:          taken = 1'b0;
		endcase
	end

	always_comb begin
		res.status      = trm_pkg::ST_OK;
		res.print_valid = 1'b0;
		res.print_value = '0;
		res.next_line   = cur_line + 17'd1;
		wb.reg_we       = 1'b0;
		wb.reg_idx      = item.reg_a;
		wb.reg_wdata    = '0;
		wb.mem_we       = 1'b0;
		wb.mem_addr     = item.mem_addr;
		wb.mem_wdata    = '0;

		if (uses_mem && !addr_ok) begin
			res.status = trm_pkg::ST_MEM;
		end else begin
			unique case (item.op)
				trm_pkg::OP_MOV_RR: begin
					wb.reg_we    = rb_ok;
					wb.reg_idx   = item.reg_b;
					wb.reg_wdata = ra_val;
				end
				trm_pkg::OP_MOV_RK: begin
					wb.reg_we    = ra_ok;
					wb.reg_wdata = k32;
				end
				trm_pkg::OP_MOV_MR: begin
					wb.mem_we    = 1'b1;
					wb.mem_wdata = ra_val;
				end
				trm_pkg::OP_MOV_RM: begin
					wb.reg_we    = ra_ok;
					wb.reg_wdata = mval;
				end
				trm_pkg::OP_MOV_MK: begin
					wb.mem_we    = 1'b1;
					wb.mem_wdata = k32;
				end
				trm_pkg::OP_ADD_K: begin
					wb.reg_we    = ra_ok;
					wb.reg_wdata = ra_val + k32;
				end
				trm_pkg::OP_ADD_R: begin
					wb.reg_we    = ra_ok;
					wb.reg_wdata = ra_val + rb_val;
				end
				trm_pkg::OP_ADD_M: begin
					wb.reg_we    = ra_ok;
					wb.reg_wdata = ra_val + mval;
				end
				trm_pkg::OP_SUB_K: begin
					wb.reg_we    = ra_ok;
					wb.reg_wdata = ra_val - k32;
				end
				trm_pkg::OP_SUB_R: begin
					wb.reg_we    = ra_ok;
					wb.reg_wdata = ra_val - rb_val;
				end
				trm_pkg::OP_SUB_M: begin
					wb.reg_we    = ra_ok;
					wb.reg_wdata = ra_val - mval;
				end
				trm_pkg::OP_JMPZ, trm_pkg::OP_JPN, trm_pkg::OP_JMP: begin
					// a jump onto the current line falls through
					if (taken) begin
						if ((tgt17 == 17'd0) || (tgt17 > jump_limit)) begin
							res.status = trm_pkg::ST_JUMP;
						end else if (tgt17 != cur_line) begin
							res.next_line = tgt17;
						end
					end
				end
				trm_pkg::OP_PRN_R: begin
					res.print_valid = 1'b1;
					res.print_value = ra_val;
				end
				trm_pkg::OP_PRN_K: begin
					res.print_valid = 1'b1;
					res.print_value = k32;
				end
				trm_pkg::OP_PRN_M: begin
					res.print_valid = 1'b1;
					res.print_value = mval;
				end
				trm_pkg::OP_HLT: begin
					res.status = trm_pkg::ST_HALT;
				end
				default: begin
				end
			endcase
		end

		if (res.status != trm_pkg::ST_OK) begin
			res.next_line = cur_line;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/trm_checker.sv
// Port-level checks for the executor core, attached to it by bind.
// Depends on trm_pkg for the status codes.
`default_nettype none

module trm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic        print_valid,
	input wire logic [31:0] print_value
);

	// hold a result word until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// a fresh result word must come from an instruction word that was taken earlier
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result word without a matching instruction word");

	a_print_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !print_valid |-> print_value == 32'd0)
		else $error("print value not zero without a print");

	a_print_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && print_valid |-> status == trm_pkg::ST_OK)
		else $error("print reported together with an error status");

endmodule

bind toy_register_machine_executor_core trm_checker u_trm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.status      (out_ch.status),
	.print_valid (out_ch.print_valid),
	.print_value (out_ch.print_value)
);

`default_nettype wire

FILE: verif/trm_exec_check_pkg.sv
// Scoreboard for the register machine executor: predicts one result word per
// instruction word and checks the block's results in order. Depends on trm_pkg.
`default_nettype none

package trm_exec_check_pkg;

	localparam int REG_COUNT = 5;
	localparam int WORD_COUNT = 64;
	localparam int SHOWN_MISMATCHES = 10;

	class exec_scoreboard;
		logic [31:0] regs [REG_COUNT];
		logic [31:0] words [WORD_COUNT];
		logic [16:0] line_now;
		logic [15:0] prog_lines;
		trm_pkg::result_t pending_results [$];
		int errors;
		int n_words;
		int n_checked;
		int n_prints;
		int n_status [4];

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (words[i]) words[i] = '0;
			foreach (n_status[i]) n_status[i] = 0;
			line_now = 17'd1;
			prog_lines = 16'd1;
			errors = 0;
			n_words = 0;
			n_checked = 0;
			n_prints = 0;
		endfunction

		// out-of-range registers read as zero and drop writes
		function logic [31:0] reg_value(logic [2:0] idx);
			return (idx < REG_COUNT) ? regs[idx] : 32'd0;
		endfunction

		function void put_reg(logic [2:0] idx, logic [31:0] v);
			if (idx < REG_COUNT)
				regs[idx] = v;
		endfunction

		function void take_word(trm_pkg::item_t w);
			logic [31:0] a_val;
			logic [31:0] b_val;
			logic [31:0] k_val;
			logic [31:0] m_val;
			logic [16:0] next;
			logic [16:0] tgt;
			logic addr_ok;
			logic mem_form;
			logic taken;
			trm_pkg::result_t r;
			a_val = reg_value(w.reg_a);
			b_val = reg_value(w.reg_b);
			k_val = {1'b0, w.constant};
			addr_ok = w.mem_addr < WORD_COUNT;
			m_val = addr_ok ? words[w.mem_addr[5:0]] : 32'd0;
			mem_form = w.op inside {trm_pkg::OP_MOV_MR, trm_pkg::OP_MOV_RM,
				trm_pkg::OP_MOV_MK, trm_pkg::OP_ADD_M, trm_pkg::OP_SUB_M,
				trm_pkg::OP_PRN_M};
			next = line_now + 17'd1;
			tgt = {1'b0, w.target_line};
			taken = 1'b0;
			r = '0;
			r.status = trm_pkg::ST_OK;
			if (mem_form && !addr_ok) begin
				r.status = trm_pkg::ST_MEM;
			end else begin
				case (w.op)
					trm_pkg::OP_MOV_RR: put_reg(w.reg_b, a_val);
					trm_pkg::OP_MOV_RK: put_reg(w.reg_a, k_val);
					trm_pkg::OP_MOV_MR: words[w.mem_addr[5:0]] = a_val;
					trm_pkg::OP_MOV_RM: put_reg(w.reg_a, m_val);
					trm_pkg::OP_MOV_MK: words[w.mem_addr[5:0]] = k_val;
					trm_pkg::OP_ADD_K: put_reg(w.reg_a, a_val + k_val);
					trm_pkg::OP_ADD_R: put_reg(w.reg_a, a_val + b_val);
					trm_pkg::OP_ADD_M: put_reg(w.reg_a, a_val + m_val);
					trm_pkg::OP_SUB_K: put_reg(w.reg_a, a_val - k_val);
					trm_pkg::OP_SUB_R: put_reg(w.reg_a, a_val - b_val);
					trm_pkg::OP_SUB_M: put_reg(w.reg_a, a_val - m_val);
					trm_pkg::OP_JMPZ: taken = (w.reg_a < REG_COUNT) && (a_val == 32'd0);
					trm_pkg::OP_JPN:
						taken = (w.reg_a < REG_COUNT) && (a_val == 32'd0 || a_val[31]);
					trm_pkg::OP_JMP: taken = 1'b1;
					trm_pkg::OP_PRN_R: begin
						r.print_valid = 1'b1;
						r.print_value = a_val;
					end
					trm_pkg::OP_PRN_K: begin
						r.print_valid = 1'b1;
						r.print_value = k_val;
					end
					trm_pkg::OP_PRN_M: begin
						r.print_valid = 1'b1;
						r.print_value = m_val;
					end
					trm_pkg::OP_HLT: r.status = trm_pkg::ST_HALT;
					default: ;
				endcase
			end
			// a target may be one past the last line; a jump onto itself falls through
			if (taken) begin
				if (tgt == 17'd0 || tgt > {1'b0, prog_lines} + 17'd1)
					r.status = trm_pkg::ST_JUMP;
				else if (tgt != line_now)
					next = tgt;
			end
			if (r.status != trm_pkg::ST_OK)
				next = line_now;
			line_now = next;
			r.next_line = next;
			pending_results.push_back(r);
			n_words++;
		endfunction

		function void match_result(trm_pkg::result_t got);
			trm_pkg::result_t want;
			string bad;
			n_checked++;
			n_status[got.status]++;
			if (got.print_valid)
				n_prints++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= SHOWN_MISMATCHES)
					$display("unexpected result word: status %0d print %0b/%0d next %0d",
						got.status, got.print_valid, got.print_value, got.next_line);
				return;
			end
			want = pending_results.pop_front();
			bad = "";
			if (got.status != want.status)
				bad = {bad, " status"};
			if (got.print_valid != want.print_valid)
				bad = {bad, " print_valid"};
			if (got.print_value != want.print_value)
				bad = {bad, " print_value"};
			if (got.next_line != want.next_line)
				bad = {bad, " next_line"};
			if (bad != "") begin
				errors++;
				if (errors <= SHOWN_MISMATCHES)
					$display({"result %0d wrong in", bad,
						": expected status %0d print %0b/%0d next %0d,",
						" got status %0d print %0b/%0d next %0d"},
						n_checked, want.status, want.print_valid, want.print_value,
						want.next_line, got.status, got.print_valid, got.print_value,
						got.next_line);
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		function void close_out();
			if (pending_results.size() != 0) begin
				errors += pending_results.size();
				$display("%0d result words never arrived", pending_results.size());
			end
		endfunction
	endclass

endpackage

`default_nettype wire

FILE: verif/testbench.sv
// Top-level testbench for toy_register_machine_executor_core: directed and random
// instruction words under several idle patterns. Depends on trm_pkg, trm_if and
// trm_exec_check_pkg.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 265;
	localparam logic [4:0] OP_UNUSED_LO = 5'd18;
	localparam logic [4:0] OP_UNUSED_HI = 5'd31;
	localparam logic [2:0] R1 = 3'd0;
	localparam logic [2:0] R2 = 3'd1;
	localparam logic [2:0] R3 = 3'd2;
	localparam logic [2:0] R4 = 3'd3;
	localparam logic [2:0] R5 = 3'd4;
	localparam logic [2:0] R_BAD_LO = 3'd5;
	localparam logic [2:0] R_BAD_HI = 3'd7;
	localparam logic [7:0] LAST_WORD = 8'd63;
	localparam logic [30:0] K_MAX = 31'h7fffffff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	int send_idle = 0;
	int recv_stall = 0;
	int cycles = 0;
	trm_exec_check_pkg::exec_scoreboard sb;

	trm_in_if in_ch();
	trm_out_if out_ch();

	toy_register_machine_executor_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk)
		out_ch.ready <= ($urandom_range(99) >= recv_stall);

	always @(posedge clk)
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.match_result({out_ch.status, out_ch.print_valid, out_ch.print_value,
				out_ch.next_line});

	function automatic trm_pkg::item_t make_word(logic [4:0] op, logic [2:0] ra,
		logic [2:0] rb, logic [7:0] addr, logic [30:0] k, logic [15:0] tgt);
		trm_pkg::item_t w;
		w.op = op;
		w.reg_a = ra;
		w.reg_b = rb;
		w.mem_addr = addr;
		w.constant = k;
		w.target_line = tgt;
		return w;
	endfunction

	// hold valid low for a random gap, then present the word until it is taken
	task automatic send_word(trm_pkg::item_t w);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= w.op;
		in_ch.reg_a <= w.reg_a;
		in_ch.reg_b <= w.reg_b;
		in_ch.mem_addr <= w.mem_addr;
		in_ch.constant <= w.constant;
		in_ch.target_line <= w.target_line;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.take_word(w);
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_lines(logic [15:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.prog_lines = v;
	endtask

	task automatic run_phase(int idle, int stall, logic [15:0] lines);
		trm_pkg::item_t w;
		int r;
		int top;
		write_lines(lines);
		send_idle = idle;
		recv_stall = stall;
		for (int i = 0; i < PHASE_WORDS; i++) begin
			// drain the pipe now and then so gaps land on an empty block too
			if ($urandom_range(149) == 0 || (idle == 0 && stall == 0 && i == 100))
				settle();
			w.op = ($urandom_range(99) < 8) ? 5'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO))
				: 5'($urandom_range(trm_pkg::OP_HLT, trm_pkg::OP_MOV_RR));
			w.reg_a = ($urandom_range(99) < 12) ? 3'($urandom_range(7, 0))
				: 3'($urandom_range(4, 0));
			w.reg_b = ($urandom_range(99) < 12) ? 3'($urandom_range(7, 0))
				: 3'($urandom_range(4, 0));
			r = $urandom_range(99);
			if (r < 12)
				w.mem_addr = 8'($urandom);
			else if (r < 50)
				w.mem_addr = 8'($urandom_range(7, 0));
			else
				w.mem_addr = 8'($urandom_range(63, 0));
			r = $urandom_range(99);
			if (r < 25)
				w.constant = '0;
			else if (r < 35)
				w.constant = K_MAX;
			else if (r < 55)
				w.constant = 31'($urandom_range(8, 0));
			else
				w.constant = 31'($urandom);
			// aim jumps at the current line, the legal range and just past it
			top = int'(sb.prog_lines) + 2;
			if (top > 65535)
				top = 65535;
			r = $urandom_range(99);
			if (r < 30)
				w.target_line = sb.line_now[15:0];
			else if (r < 75)
				w.target_line = 16'($urandom_range(top, 1));
			else if (r < 80)
				w.target_line = '0;
			else
				w.target_line = 16'($urandom);
			send_word(w);
		end
	endtask

	initial begin
		sb = new();
		in_ch.valid <= 1'b0;
		in_ch.op <= '0;
		in_ch.reg_a <= '0;
		in_ch.reg_b <= '0;
		in_ch.mem_addr <= '0;
		in_ch.constant <= '0;
		in_ch.target_line <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words under the reset program length of one line
		send_word(make_word(trm_pkg::OP_MOV_RK, R1, R1, 8'd0, K_MAX, 16'd0));
		send_word(make_word(trm_pkg::OP_ADD_K, R1, R1, 8'd0, K_MAX, 16'd0));
		send_word(make_word(trm_pkg::OP_ADD_K, R1, R1, 8'd0, 31'd2, 16'd0));
		send_word(make_word(trm_pkg::OP_SUB_K, R2, R1, 8'd0, 31'd1, 16'd0));
		send_word(make_word(trm_pkg::OP_MOV_RR, R2, R3, 8'd0, 31'd0, 16'd0));
		send_word(make_word(trm_pkg::OP_MOV_MR, R3, R1, LAST_WORD, 31'd0, 16'd0));
		send_word(make_word(trm_pkg::OP_MOV_RM, R4, R1, LAST_WORD, 31'd0, 16'd0));
		send_word(make_word(trm_pkg::OP_MOV_MK, R1, R1, 8'd0, K_MAX, 16'd0));
		send_word(make_word(trm_pkg::OP_MOV_MK, R1, R1, LAST_WORD + 8'd1, 31'd5, 16'd0));
		send_word(make_word(trm_pkg::OP_ADD_M, R5, R1, 8'hff, 31'd0, 16'd0));
		send_word(make_word(trm_pkg::OP_ADD_R, R4, R2, 8'd0, 31'd0, 16'd0));
		send_word(make_word(trm_pkg::OP_SUB_R, R1, R3, 8'd0, 31'd0, 16'd0));
		send_word(make_word(trm_pkg::OP_SUB_M, R5, R1, LAST_WORD, 31'd0, 16'd0));
		send_word(make_word(trm_pkg::OP_PRN_R, R3, R1, 8'd0, 31'd0, 16'd0));
		send_word(make_word(trm_pkg::OP_PRN_K, R1, R1, 8'd0, K_MAX, 16'd0));
		send_word(make_word(trm_pkg::OP_PRN_M, R1, R1, 8'd0, 31'd0, 16'd0));
		send_word(make_word(trm_pkg::OP_PRN_M, R1, R1, 8'h80, 31'd0, 16'd0));
		send_word(make_word(trm_pkg::OP_JMPZ, R1, R1, 8'd0, 31'd0, 16'd0));
		send_word(make_word(trm_pkg::OP_MOV_RK, R5, R1, 8'd0, 31'd0, 16'd0));
		send_word(make_word(trm_pkg::OP_JMPZ, R5, R1, 8'd0, 31'd0, 16'd0));
		send_word(make_word(trm_pkg::OP_JPN, R2, R1, 8'd0, 31'd0, 16'd2));
		send_word(make_word(trm_pkg::OP_JMP, R1, R1, 8'd0, 31'd0, 16'd3));
		send_word(make_word(trm_pkg::OP_JMP, R1, R1, 8'd0, 31'd0, sb.line_now[15:0]));
		send_word(make_word(trm_pkg::OP_JPN, R_BAD_HI, R1, 8'd0, 31'd0, 16'd0));
		send_word(make_word(trm_pkg::OP_MOV_RK, R_BAD_LO, R1, 8'd0, 31'd9, 16'd0));
		send_word(make_word(trm_pkg::OP_PRN_R, R_BAD_LO, R1, 8'd0, 31'd0, 16'd0));
		send_word(make_word(trm_pkg::OP_HLT, R1, R1, 8'd0, 31'd0, 16'd0));
		send_word(make_word(OP_UNUSED_LO, R1, R1, 8'd0, 31'd0, 16'd0));
		send_word(make_word(OP_UNUSED_HI, R_BAD_HI, R_BAD_HI, 8'hff, K_MAX, 16'hffff));

		run_phase(0, 0, 16'hffff);
		run_phase(73, 0, 16'd1);
		run_phase(0, 73, 16'($urandom_range(300, 2)));
		run_phase(19, 19, 16'd40);

		settle();
		repeat (8) @(posedge clk);
		sb.close_out();
		$display("ran %0d instruction words, checked %0d results (%0d prints)",
			sb.n_words, sb.n_checked, sb.n_prints);
		$display("statuses seen: %0d ok, %0d address errors, %0d bad jumps, %0d halts",
			sb.n_status[trm_pkg::ST_OK], sb.n_status[trm_pkg::ST_MEM],
			sb.n_status[trm_pkg::ST_JUMP], sb.n_status[trm_pkg::ST_HALT]);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/trm_pkg.sv
hw/rtl/trm_if.sv
hw/rtl/trm_dmem.sv
hw/rtl/trm_exec.sv
hw/rtl/toy_register_machine_executor_core.sv
hw/rtl/trm_checker.sv
verif/trm_exec_check_pkg.sv
verif/testbench.sv
